// File: rtl/bfwm_pkg.sv
// Shared field widths and operation codes for the window-mean FIFO.
package bfwm_pkg;

    // Beat field widths
    localparam int FUNC_W   = 1;
    localparam int ID_W     = 12;
    localparam int HEIGHT_W = 8;
    localparam int MEAN_W   = 8;
    localparam int FILL_W   = 3;

    // Operation codes carried in func
    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } func_t;

endpackage

// File: rtl/bfwm_if.sv
// Command and response channel interfaces (valid/ready) of the window-mean FIFO.
interface bfwm_cmd_if
    import bfwm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [ID_W-1:0]     item_id;
    logic [HEIGHT_W-1:0] height;

    modport source (output valid, func, item_id, height, input ready);
    modport sink   (input valid, func, item_id, height, output ready);
endinterface

interface bfwm_rsp_if
    import bfwm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MEAN_W-1:0] mean_height;
    logic [ID_W-1:0]   removed_id;
    logic              empty_error;
    logic [FILL_W-1:0] fill_count;

    modport source (output valid, mean_height, removed_id, empty_error, fill_count,
                    input ready);
    modport sink   (input valid, mean_height, removed_id, empty_error, fill_count,
                    output ready);
endinterface

// File: rtl/bounded_fifo_window_mean.sv
// Window-mean FIFO: insert returns the rounded mean height, remove pops the oldest id.
// Remove: result registered at the accept edge, 1 beat per cycle while the response side keeps ready high.
// Insert: an accept step, then a restoring divider that yields one quotient bit per cycle;
// command ready is low while it runs.
// Reset (rst_n, async low) clears head, count, sum, sequencer and output valid;
// the id and height stores are not cleared and are read only once written.
module bounded_fifo_window_mean
    import bfwm_pkg::*;
#(
    parameter int CAPACITY = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    bfwm_cmd_if.sink    cmd,
    bfwm_rsp_if.source  rsp
);

    // Derived widths
    localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int TW    = $clog2(2 * CAPACITY + 1);
    localparam int SW    = $clog2(255 * CAPACITY + 1);
    localparam int NUM_W = $clog2(511 * CAPACITY + 1);
    localparam int DW    = $clog2(2 * CAPACITY + 1);
    localparam int BW    = $clog2(NUM_W + 1);

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } state_t;

    state_t            state_reg, state_next;
    logic [IW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [SW-1:0]     sum_reg, sum_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [DW-1:0]     den_reg, den_next;
    logic [DW-1:0]     rem_reg, rem_next;
    logic [BW-1:0]     bit_cnt_reg, bit_cnt_next;

    logic              out_valid_reg, out_valid_next;
    logic [MEAN_W-1:0] mean_reg, mean_next;
    logic [ID_W-1:0]   rid_reg, rid_next;
    logic              err_reg, err_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    logic [ID_W-1:0]     id_store_reg     [CAPACITY];
    logic [HEIGHT_W-1:0] height_store_reg [CAPACITY];

    logic              accept;
    logic              load_out;
    logic              wr_en;
    logic              full;
    logic [IW-1:0]     head_inc;
    logic [IW-1:0]     head_ins;
    logic [CW-1:0]     cnt_base;
    logic [CW-1:0]     count_ins;
    logic [SW-1:0]     sum_base;
    logic [SW-1:0]     sum_ins;
    logic [TW-1:0]     tail_sum;
    logic [IW-1:0]     tail;
    logic [HEIGHT_W-1:0] head_height;
    logic [DW:0]       rem_shift;
    logic              quo_bit;

    assign cmd.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = cmd.valid && cmd.ready;

    // Oldest entry and the slot after it
    assign head_height = height_store_reg[head_reg];
    assign head_inc    = (head_reg == IW'(CAPACITY - 1)) ? '0 : head_reg + IW'(1);
    assign full        = (count_reg == CW'(CAPACITY));

    // Insert path: evict when full, then append at the tail
    assign head_ins  = full ? head_inc : head_reg;
    assign cnt_base  = full ? count_reg - CW'(1) : count_reg;
    assign sum_base  = full ? sum_reg - SW'(head_height) : sum_reg;
    assign sum_ins   = sum_base + SW'(cmd.height);
    assign count_ins = cnt_base + CW'(1);
    assign tail_sum  = TW'(head_ins) + TW'(cnt_base);
    assign tail      = (tail_sum >= TW'(CAPACITY)) ? IW'(tail_sum - TW'(CAPACITY))
                                                   : IW'(tail_sum);
    assign wr_en     = accept && (cmd.func == FUNC_INSERT);

    // Divider step: shift in next numerator bit, subtract when it fits
    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign quo_bit   = (rem_shift >= {1'b0, den_reg});

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        bit_cnt_next   = bit_cnt_reg;
        mean_next      = mean_reg;
        rid_next       = rid_reg;
        err_next       = err_reg;
        fill_next      = fill_reg;
        load_out       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.func == FUNC_INSERT)
                    begin
                        head_next    = head_ins;
                        count_next   = count_ins;
                        sum_next     = sum_ins;
                        // (2*sum + count) / (2*count)
                        num_next     = NUM_W'({sum_ins, 1'b0}) + NUM_W'(count_ins);
                        den_next     = DW'({count_ins, 1'b0});
                        rem_next     = '0;
                        bit_cnt_next = BW'(NUM_W);
                        state_next   = ST_DIV;
                    end
                    else if (count_reg == '0)
                    begin
                        load_out  = 1'b1;
                        mean_next = '0;
                        rid_next  = '0;
                        err_next  = 1'b1;
                        fill_next = '0;
                    end
                    else
                    begin
                        head_next  = head_inc;
                        count_next = count_reg - CW'(1);
                        sum_next   = sum_reg - SW'(head_height);
                        load_out   = 1'b1;
                        mean_next  = '0;
                        rid_next   = id_store_reg[head_reg];
                        err_next   = 1'b0;
                        fill_next  = FILL_W'(count_reg - CW'(1));
                    end
                end
            end
            ST_DIV:
            begin
                rem_next     = quo_bit ? DW'(rem_shift - {1'b0, den_reg}) : rem_shift[DW-1:0];
                num_next     = {num_reg[NUM_W-2:0], quo_bit};
                bit_cnt_next = bit_cnt_reg - BW'(1);
                if (bit_cnt_reg == BW'(1))
                begin
                    load_out   = 1'b1;
                    mean_next  = MEAN_W'({num_reg[NUM_W-2:0], quo_bit});
                    rid_next   = '0;
                    err_next   = 1'b0;
                    fill_next  = FILL_W'(count_reg);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Output register: freed on take, set on a new result
        out_valid_next = out_valid_reg && !rsp.ready;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    // State, control and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath and payload, no reset
    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        mean_reg <= mean_next;
        rid_reg  <= rid_next;
        err_reg  <= err_next;
        fill_reg <= fill_next;
        if (wr_en)
        begin
            id_store_reg[tail]     <= cmd.item_id;
            height_store_reg[tail] <= cmd.height;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.mean_height = mean_reg;
    assign rsp.removed_id  = rid_reg;
    assign rsp.empty_error = err_reg;
    assign rsp.fill_count  = fill_reg;

`ifndef ASSERT_OFF
    // Never more items than slots
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("item count above capacity");

    // A pending beat is never overwritten by a new result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |-> !load_out)
        else $error("result overwrote a pending beat");

    // Divider always has bits left while running
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (bit_cnt_reg != '0))
        else $error("divider ran past its last bit");

    // An empty-queue remove reports nothing else
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.empty_error) |->
            (rsp.fill_count == '0 && rsp.removed_id == '0 && rsp.mean_height == '0))
        else $error("empty error with nonzero fields");
`endif

endmodule
